// ----- rtl/core/swase_pkg.sv -----
// shared types and constants for the sliding window angle speed estimator
package swase_pkg;

    localparam int ANGLE_W     = 12;
    localparam int INC_W       = 12;
    localparam int SPEED_W     = 15;
    localparam int WRAP_W      = 14;

    localparam int WRAP_OFFSET = 7200;
    localparam int FULL_TURN   = 3600;
    localparam int BACK_LIMIT  = 2000;
    localparam int BACK_SUBST  = 5;
    localparam int INC_MAX     = 3599;

    localparam int SCALE_NUM   = 400;
    localparam int SCALE_DEN   = 3;
    localparam int SPEED_MAX   = 32767;

    typedef logic [ANGLE_W-1:0] t_angle;
    typedef logic [INC_W-1:0]   t_inc;
    typedef logic [SPEED_W-1:0] t_speed;

    // status carried alongside an item between pipeline stages
    typedef struct packed {
        logic vld;
        logic speed_valid;
    } t_stage;

endpackage

// ----- rtl/core/sliding_window_angle_speed_estimator.sv -----
// an accepted item goes through the input register and the window update to the result register
// throughput: one item per cycle; input register, window update and result register move
// together, so a stall on the master side holds all three stages
// the window update (ring slot, running sum) is done once per item
// reset (synchronous, active low) empties the pipeline and restarts warm-up
// the ring itself is not cleared: warm-up writes every slot before any is read back
module sliding_window_angle_speed_estimator
    import swase_pkg::*;
#(
    parameter int WINDOW_LENGTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // angle_now[11:0], angle_before[23:12]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // speed_estimate[14:0], zero[15]
    output logic        o_m_tuser    // speed_valid[0]
);

    localparam int SUM_W = $clog2(WINDOW_LENGTH * INC_MAX + 1);

    logic             adv;
    logic             r_in_vld;
    t_angle           r_now;
    t_angle           r_before;
    t_inc             inc;
    logic             small_back;
    logic [SUM_W-1:0] win_sum;
    logic             win_flag;
    logic             r_b_vld;
    t_stage           b_stage;
    t_stage           out_stage;
    t_speed           out_speed;

    assign adv        = !out_stage.vld || i_m_tready;
    assign o_s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_b_vld  <= 1'b0;
        end else if (adv) begin
            r_in_vld <= i_s_tvalid;
            r_b_vld  <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_s_tvalid) begin
            r_now    <= i_s_tdata[ANGLE_W-1:0];
            r_before <= i_s_tdata[2*ANGLE_W-1:ANGLE_W];
        end
    end

    swase_incr u_incr (
        .i_angle_now    (r_now),
        .i_angle_before (r_before),
        .o_inc          (inc),
        .o_small_back   (small_back)
    );

    swase_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv && r_in_vld),
        .i_inc         (inc),
        .i_small_back  (small_back),
        .o_sum         (win_sum),
        .o_speed_valid (win_flag)
    );

    assign b_stage.vld         = r_b_vld;
    assign b_stage.speed_valid = win_flag;

    swase_scale #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SUM_W         (SUM_W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_stage (b_stage),
        .i_sum   (win_sum),
        .o_stage (out_stage),
        .o_speed (out_speed)
    );

    assign o_m_tvalid = out_stage.vld;
    assign o_m_tdata  = {1'b0, out_speed};
    assign o_m_tuser  = out_stage.speed_valid;

    // warm-up results carry a zero speed
    a_warmup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 16'd0))
        else $error("warm-up result with nonzero speed");

    // once a full-window result has gone out, no warm-up result follows
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |=> !(o_m_tvalid && !o_m_tuser))
        else $error("warm-up result after window filled");

    // an accepted item always lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_in_vld)
        else $error("accepted item lost at input register");

    // an item in the window stage moves on to the result register when not stalled
    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && adv) |=> o_m_tvalid)
        else $error("item dropped between window and result stages");

endmodule

// ----- rtl/core/swase_incr.sv -----
// wrapped angle increment and small backward step detection
module swase_incr
    import swase_pkg::*;
(
    input  t_angle i_angle_now,
    input  t_angle i_angle_before,
    output t_inc   o_inc,
    output logic   o_small_back
);

    logic [WRAP_W-1:0]  wrap_sum;
    logic [ANGLE_W-1:0] back_diff;

    // d + 7200 always lies in 3105..11295, so 14-bit wraparound math is exact
    assign wrap_sum = WRAP_W'(i_angle_now) + WRAP_W'(WRAP_OFFSET) - WRAP_W'(i_angle_before);

    always_comb begin
        if (wrap_sum >= WRAP_W'(3 * FULL_TURN)) begin
            o_inc = INC_W'(wrap_sum - WRAP_W'(3 * FULL_TURN));
        end else if (wrap_sum >= WRAP_W'(2 * FULL_TURN)) begin
            o_inc = INC_W'(wrap_sum - WRAP_W'(2 * FULL_TURN));
        end else if (wrap_sum >= WRAP_W'(FULL_TURN)) begin
            o_inc = INC_W'(wrap_sum - WRAP_W'(FULL_TURN));
        end else begin
            o_inc = INC_W'(wrap_sum);
        end
    end

    assign back_diff    = i_angle_before - i_angle_now;
    assign o_small_back = (i_angle_before > i_angle_now) && (back_diff < ANGLE_W'(BACK_LIMIT));

endmodule

// ----- rtl/core/swase_window.sv -----
// increment ring, running sum, write index and warm-up tracking
module swase_window
    import swase_pkg::*;
#(
    parameter int WINDOW_LENGTH = 16,
    parameter int SUM_W         = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_inc             i_inc,
    input  logic             i_small_back,
    output logic [SUM_W-1:0] o_sum,
    output logic             o_speed_valid
);

    localparam int IDX_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;

    t_inc             ring_mem [WINDOW_LENGTH];
    t_inc             r_old;
    t_inc             wr_inc;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] rd_addr;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic             r_full;
    logic             n_full;
    logic             r_flag;
    logic             wrap_idx;

    assign wrap_idx = (r_idx == IDX_W'(WINDOW_LENGTH - 1));
    assign wr_inc   = (!r_full && i_small_back) ? INC_W'(BACK_SUBST) : i_inc;

    always_comb begin
        n_idx  = r_idx;
        n_full = r_full;
        n_sum  = r_sum;
        if (i_en) begin
            n_idx  = wrap_idx ? '0 : r_idx + IDX_W'(1);
            n_full = r_full | wrap_idx;
            if (r_full) begin
                n_sum = r_sum - SUM_W'(r_old) + SUM_W'(wr_inc);
            end else begin
                n_sum = r_sum + SUM_W'(wr_inc);
            end
        end
    end

    // read port prefetches the slot that the next item will overwrite
    assign rd_addr = i_en ? n_idx : r_idx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ring_mem[r_idx] <= wr_inc;
        end
        if (i_en && (rd_addr == r_idx)) begin
            r_old <= wr_inc;
        end else begin
            r_old <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_sum  <= '0;
            r_full <= 1'b0;
            r_flag <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_sum  <= n_sum;
            r_full <= n_full;
            if (i_en) begin
                r_flag <= r_full;
            end
        end
    end

    assign o_sum         = r_sum;
    assign o_speed_valid = r_flag;

endmodule

// ----- rtl/core/swase_scale.sv -----
// speed scaling by reciprocal multiply, saturation, zero speed during warm-up and result register
module swase_scale
    import swase_pkg::*;
#(
    parameter int WINDOW_LENGTH = 16,
    parameter int SUM_W         = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_stage           i_stage,
    input  logic [SUM_W-1:0] i_sum,
    output t_stage           o_stage,
    output t_speed           o_speed
);

    // floor(sum*400/(3*W)) equals (sum*MULT)>>SHIFT while sum*err < 2^SHIFT
    localparam longint unsigned DEN    = longint'(SCALE_DEN) * longint'(WINDOW_LENGTH);
    localparam int              SHIFT  = SUM_W + 8;
    localparam longint unsigned MULT   =
        (longint'(SCALE_NUM) * (64'd1 << SHIFT) + DEN - 64'd1) / DEN;
    localparam int              MULT_W = $clog2(MULT + 64'd1);
    localparam int              PROD_W = SUM_W + MULT_W;
    localparam int              Q_W    = PROD_W - SHIFT;

    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]    quot;
    t_speed            n_speed;
    t_stage            r_stage;
    t_speed            r_speed;

    assign prod = PROD_W'(i_sum) * PROD_W'(MULT_W'(MULT));
    assign quot = prod[PROD_W-1:SHIFT];

    always_comb begin
        if (!i_stage.speed_valid) begin
            n_speed = '0;
        end else if (32'(quot) > 32'(SPEED_MAX)) begin
            n_speed = SPEED_W'(SPEED_MAX);
        end else begin
            n_speed = quot[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else if (i_en) begin
            r_stage <= i_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_speed <= n_speed;
        end
    end

    assign o_stage = r_stage;
    assign o_speed = r_speed;

endmodule

// ----- tb/sv/sliding_window_angle_speed_estimator_tb.sv -----
// self-checking testbench for the sliding window angle speed estimator
module sliding_window_angle_speed_estimator_tb;
    import swase_pkg::*;

    localparam int WINDOW      = 16;
    localparam int HOLD_CYCLES = 80;
    localparam int DIR_ROWS    = 24;
    localparam int RAND_ITEMS  = 800;

    typedef struct packed {
        t_speed speed;
        logic   valid;
    } t_speed_expect;

    typedef struct packed {
        t_angle angle_now;
        t_angle angle_before;
        logic   pinned;
        t_speed speed;
        logic   valid;
    } t_sample_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // angle_now[11:0], angle_before[23:12]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // speed_estimate[14:0], zero[15]
    logic        o_m_tuser;         // speed_valid[0]

    sliding_window_angle_speed_estimator #(
        .WINDOW_LENGTH(WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // warm-up rows are pinned to zero speed, later rows go through the window model
    t_sample_row stim_rows [DIR_ROWS] = '{
        '{12'd0,    12'd0,    1'b1, 15'd0, 1'b0},
        '{12'd3599, 12'd0,    1'b1, 15'd0, 1'b0},
        '{12'd0,    12'd3599, 1'b1, 15'd0, 1'b0},
        '{12'd100,  12'd200,  1'b1, 15'd0, 1'b0},
        '{12'd0,    12'd1999, 1'b1, 15'd0, 1'b0},
        '{12'd0,    12'd2000, 1'b1, 15'd0, 1'b0},
        '{12'd4095, 12'd0,    1'b1, 15'd0, 1'b0},
        '{12'd0,    12'd4095, 1'b1, 15'd0, 1'b0},
        '{12'd4095, 12'd4095, 1'b1, 15'd0, 1'b0},
        '{12'd2730, 12'd1365, 1'b1, 15'd0, 1'b0},
        '{12'd1365, 12'd2730, 1'b1, 15'd0, 1'b0},
        '{12'd3599, 12'd3598, 1'b1, 15'd0, 1'b0},
        '{12'd10,   12'd3590, 1'b1, 15'd0, 1'b0},
        '{12'd1,    12'd2,    1'b1, 15'd0, 1'b0},
        '{12'd2000, 12'd0,    1'b1, 15'd0, 1'b0},
        '{12'd0,    12'd0,    1'b1, 15'd0, 1'b0},
        '{12'd100,  12'd200,  1'b0, 15'd0, 1'b0},
        '{12'd0,    12'd0,    1'b0, 15'd0, 1'b0},
        '{12'd3599, 12'd0,    1'b0, 15'd0, 1'b0},
        '{12'd0,    12'd4095, 1'b0, 15'd0, 1'b0},
        '{12'd50,   12'd50,   1'b0, 15'd0, 1'b0},
        '{12'd1,    12'd0,    1'b0, 15'd0, 1'b0},
        '{12'd3000, 12'd2999, 1'b0, 15'd0, 1'b0},
        '{12'd4095, 12'd4095, 1'b0, 15'd0, 1'b0}
    };

    // window model state
    t_inc        window_incs [WINDOW];
    int unsigned window_sum    = 0;
    int unsigned window_slot   = 0;
    bit          window_filled = 1'b0;

    t_speed_expect pending_speeds [$];
    int            mismatch_count = 0;

    // sender side bookkeeping
    logic          row_pinned    = 1'b0;
    t_speed_expect row_expect    = '0;
    logic          hold_request  = 1'b0;
    int            burst_left    = 0;
    int            gapless_left  = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task advance_window(input t_angle a_now, input t_angle a_before,
                        output t_speed speed, output logic valid);
        int          diff;
        int unsigned inc;
        int unsigned scaled;
        begin
            diff = int'(a_now) - int'(a_before);
            // short backward steps only get patched while the window is filling
            if (!window_filled && diff > -BACK_LIMIT && diff < 0)
                inc = BACK_SUBST;
            else
                inc = (diff + WRAP_OFFSET) % FULL_TURN;
            speed = '0;
            valid = 1'b0;
            if (window_filled)
                window_sum -= window_incs[window_slot];
            window_incs[window_slot] = t_inc'(inc);
            window_sum += inc;
            if (window_filled) begin
                scaled = window_sum * SCALE_NUM / (SCALE_DEN * WINDOW);
                speed  = (scaled > SPEED_MAX) ? t_speed'(SPEED_MAX) : t_speed'(scaled);
                valid  = 1'b1;
            end
            window_slot++;
            if (window_slot >= WINDOW) begin
                window_slot   = 0;
                window_filled = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_speed_expect predicted;
        t_speed_expect oldest;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                advance_window(i_s_tdata[11:0], i_s_tdata[23:12],
                               predicted.speed, predicted.valid);
                pending_speeds.push_back(row_pinned ? row_expect : predicted);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_speeds.size() == 0) begin
                    $display("%0t unexpected item: tdata %h tuser %b",
                             $time, o_m_tdata, o_m_tuser);
                    mismatch_count++;
                end else begin
                    oldest = pending_speeds.pop_front();
                    if (o_m_tdata[14:0] !== oldest.speed || o_m_tdata[15] !== 1'b0 ||
                        o_m_tuser !== oldest.valid) begin
                        $display({"%0t expected speed %0d pad 0 valid %b,",
                                  " got speed %0d pad %b valid %b"},
                                 $time, oldest.speed, oldest.valid,
                                 o_m_tdata[14:0], o_m_tdata[15], o_m_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver: segments of different stall patterns, plus one long hold-off on request
    initial begin
        int seg_len;
        int pattern;
        forever begin
            seg_len = $urandom_range(10, 150);
            pattern = $urandom_range(0, 3);
            repeat (seg_len) begin
                if (hold_request) begin
                    hold_request <= 1'b0;
                    i_m_tready   <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (pattern)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= ($urandom_range(0, 3) != 0);
                    2: i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= !i_m_tready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    task offer_sample(input t_angle a_now, input t_angle a_before,
                      input logic pinned, input t_speed_expect pinned_exp);
        int gap;
        begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {a_before, a_now};
            row_pinned <= pinned;
            row_expect <= pinned_exp;
            do @(posedge i_clk); while (!o_s_tready);
            if (gapless_left > 0) begin
                gapless_left--;
            end else if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(0, 6);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
                if (gap > 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        int     kind;
        int     a_now;
        int     a_before;
        int     drain;
        t_angle corner [3];
        corner = '{12'd0, 12'd3599, 12'd4095};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r])
            offer_sample(stim_rows[r].angle_now, stim_rows[r].angle_before,
                         stim_rows[r].pinned, {stim_rows[r].speed, stim_rows[r].valid});

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 250) begin
                // let the pipeline run dry before going on
                i_s_tvalid <= 1'b0;
                while (pending_speeds.size() != 0) @(posedge i_clk);
            end
            if (n == 500) begin
                // back up the output while items keep coming
                hold_request <= 1'b1;
                gapless_left = 40;
            end
            kind     = $urandom_range(0, 15);
            a_before = $urandom_range(0, FULL_TURN - 1);
            case (kind)
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                    a_now = (a_before + $urandom_range(0, 240)) % FULL_TURN;
                9, 10:
                    a_now = (a_before + $urandom_range(241, FULL_TURN - 1)) % FULL_TURN;
                11:
                    a_now = (a_before + FULL_TURN - $urandom_range(1, BACK_LIMIT - 1)) % FULL_TURN;
                12, 13: begin
                    a_now    = $urandom_range(0, 4095);
                    a_before = $urandom_range(0, 4095);
                end
                14:
                    a_now = a_before;
                default: begin
                    a_now    = corner[$urandom_range(0, 2)];
                    a_before = corner[$urandom_range(0, 2)];
                end
            endcase
            offer_sample(t_angle'(a_now), t_angle'(a_before), 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;

        for (drain = 0; pending_speeds.size() != 0 && drain < 20000; drain++)
            @(posedge i_clk);
        if (pending_speeds.size() != 0) begin
            $display("%0t %0d expected items never arrived", $time, pending_speeds.size());
            mismatch_count++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
